// ===== src/bms_pkg.sv =====
// Shared types for the bottom-up merge sorter.
// No dependencies; imported by the controller, the datapath and the top level.
package bms_pkg;

    // One stored record: signed Q8.8 key plus opaque payload
    typedef struct packed {
        logic [15:0] key;
        logic [31:0] payload;
    } t_rec;

    // Controller to datapath command flags
    typedef struct packed {
        logic load_wr;   // write the incoming beat into store a
        logic merge_wr;  // write the merge winner into the destination store
        logic src_a;     // store a is the merge source (store b takes the result)
        logic take_i;    // winner comes from the first run (read port 0)
        logic out_load;  // capture read port 0 into the output register
        logic out_last;  // final record of the sorted set
        logic out_drop;  // set lost records over capacity
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic key_lt;    // key on port 0 is strictly below key on port 1
    } t_sts;

endpackage

// ===== src/bms_datapath.sv =====
// Datapath of the merge sorter: two ping-pong record stores, key compare
// and the output register. Depends on bms_pkg for t_rec, t_cmd and t_sts.
module bms_datapath
    import bms_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int AW          = 6
) (
    input  logic          i_clk,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_rd_addr0,
    input  logic [AW-1:0] i_rd_addr1,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_key,
    input  logic [31:0]   i_payload,
    output t_sts          o_sts,
    output logic [15:0]   o_key_res,
    output logic [31:0]   o_payload_res,
    output logic          o_last_res,
    output logic          o_dropped
);

    t_rec r_mem_a [MAX_RECORDS];
    t_rec r_mem_b [MAX_RECORDS];
    t_rec r_rda0, r_rda1, r_rdb0, r_rdb1;
    t_rec rec0, rec1, wr_data;
    logic we_a, we_b;

    logic [15:0] r_out_key;
    logic [31:0] r_out_payload;
    logic        r_out_last;
    logic        r_out_drop;

    // Source selection for the two merge heads
    assign rec0 = i_cmd.src_a ? r_rda0 : r_rdb0;
    assign rec1 = i_cmd.src_a ? r_rda1 : r_rdb1;

    // Strict signed compare; a tie goes to the second run
    assign o_sts.key_lt = $signed(rec0.key) < $signed(rec1.key);

    // Write data: incoming beat while loading, merge winner otherwise
    assign wr_data = i_cmd.load_wr ? t_rec'{key: i_key, payload: i_payload}
                                   : (i_cmd.take_i ? rec0 : rec1);
    assign we_a = i_cmd.load_wr | (i_cmd.merge_wr & ~i_cmd.src_a);
    assign we_b = i_cmd.merge_wr & i_cmd.src_a;

    // Store a: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[i_wr_addr] <= wr_data;
        end
        r_rda0 <= r_mem_a[i_rd_addr0];
        r_rda1 <= r_mem_a[i_rd_addr1];
    end

    // Store b: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[i_wr_addr] <= wr_data;
        end
        r_rdb0 <= r_mem_b[i_rd_addr0];
        r_rdb1 <= r_mem_b[i_rd_addr1];
    end

    // Output register, held while the beat is stalled
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_key     <= rec0.key;
            r_out_payload <= rec0.payload;
            r_out_last    <= i_cmd.out_last;
            r_out_drop    <= i_cmd.out_drop;
        end
    end

    assign o_key_res     = r_out_key;
    assign o_payload_res = r_out_payload;
    assign o_last_res    = r_out_last;
    assign o_dropped     = r_out_drop;

endmodule

// ===== src/bms_ctrl.sv =====
// Controller of the merge sorter: load, merge-pass and emit sequencing with
// the run pointers. Depends on bms_pkg for t_cmd and t_sts.
module bms_ctrl
    import bms_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  t_sts          i_sts,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_rd_addr0,
    output logic [AW-1:0] o_rd_addr1,
    output logic [AW-1:0] o_wr_addr
);

    localparam int SW = CW + 2;

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_RUN       = 3'd1;
    localparam logic [2:0] S_READ      = 3'd2;
    localparam logic [2:0] S_MERGE     = 3'd3;
    localparam logic [2:0] S_EMIT_RD   = 3'd4;
    localparam logic [2:0] S_EMIT_LD   = 3'd5;
    localparam logic [2:0] S_EMIT_WAIT = 3'd6;

    localparam logic [CW-1:0] CAP = CW'(MAX_RECORDS);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW:0]   r_run, n_run;
    logic          r_src_a, n_src_a;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_o, n_o;
    logic [CW-1:0] r_e, n_e;
    logic          r_ovalid, n_ovalid;

    logic          i_act, j_act, take_i, e_last;
    logic [SW-1:0] mid_w, hi_w, count_w;
    logic [CW:0]   run2;

    assign i_act   = r_i < r_mid;
    assign j_act   = r_j < r_hi;
    assign take_i  = i_act & (~j_act | i_sts.key_lt);
    assign e_last  = CW'(r_e + 1'b1) == r_count;
    assign count_w = SW'(r_count);
    assign mid_w   = SW'(r_lo) + SW'(r_run);
    assign hi_w    = SW'(r_lo) + SW'({r_run, 1'b0});
    assign run2    = {r_run[CW-1:0], 1'b0};

    // Next-state and command logic
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_run    = r_run;
        n_src_a  = r_src_a;
        n_lo     = r_lo;
        n_i      = r_i;
        n_j      = r_j;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_o      = r_o;
        n_e      = r_e;
        n_ovalid = r_ovalid;

        o_cmd          = '0;
        o_cmd.src_a    = r_src_a;
        o_cmd.take_i   = take_i;
        o_cmd.out_last = e_last;
        o_cmd.out_drop = r_ovf;
        o_rd_addr0     = r_i[AW-1:0];
        o_rd_addr1     = r_j[AW-1:0];
        o_wr_addr      = r_o[AW-1:0];

        case (r_state)
            // Collect beats into store a until the one marked last; beats over capacity only set the overflow flag
            S_LOAD: begin
                o_wr_addr = r_count[AW-1:0];
                if (i_in_valid) begin
                    if (r_count < CAP) begin
                        o_cmd.load_wr = 1'b1;
                        n_count       = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_run   = (CW+1)'(1);
                        n_src_a = 1'b1;
                        n_lo    = '0;
                        n_o     = '0;
                        n_state = S_RUN;
                    end
                end
            end

            // Set up the next run pair, or close the pass
            S_RUN: begin
                if (r_lo >= r_count) begin
                    n_run   = run2;
                    n_src_a = ~r_src_a;
                    n_lo    = '0;
                    n_o     = '0;
                    if (run2 < (CW+1)'(r_count)) begin
                        n_state = S_RUN;
                    end else begin
                        n_e     = '0;
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    n_i     = r_lo;
                    n_mid   = (mid_w < count_w) ? mid_w[CW-1:0] : r_count;
                    n_j     = (mid_w < count_w) ? mid_w[CW-1:0] : r_count;
                    n_hi    = (hi_w < count_w) ? hi_w[CW-1:0] : r_count;
                    n_state = S_READ;
                end
            end

            // Fetch the two run heads
            S_READ: begin
                n_state = S_MERGE;
            end

            // One record per cycle; the next heads are fetched right away
            S_MERGE: begin
                o_cmd.merge_wr = 1'b1;
                n_o            = r_o + 1'b1;
                if (take_i) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                o_rd_addr0 = n_i[AW-1:0];
                o_rd_addr1 = n_j[AW-1:0];
                if (n_i == r_mid && n_j == r_hi) begin
                    n_lo    = r_hi;
                    n_state = S_RUN;
                end
            end

            S_EMIT_RD: begin
                o_rd_addr0 = r_e[AW-1:0];
                n_state    = S_EMIT_LD;
            end

            S_EMIT_LD: begin
                o_rd_addr0     = r_e[AW-1:0];
                o_cmd.out_load = 1'b1;
                n_ovalid       = 1'b1;
                n_state        = S_EMIT_WAIT;
            end

            // Hold the beat until taken, then read the next record; taking the final beat clears the set
            S_EMIT_WAIT: begin
                o_rd_addr0 = r_e[AW-1:0];
                if (!i_out_stall) begin
                    n_ovalid = 1'b0;
                    if (e_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_run   = (CW+1)'(1);
                        n_state = S_LOAD;
                    end else begin
                        n_e        = r_e + 1'b1;
                        o_rd_addr0 = n_e[AW-1:0];
                        n_state    = S_EMIT_LD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_run    <= (CW+1)'(1);
            r_src_a  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_run    <= n_run;
            r_src_a  <= n_src_a;
            r_ovalid <= n_ovalid;
        end
    end

    // Pointers, only meaningful inside a sort
    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_i   <= n_i;
        r_j   <= n_j;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_o   <= n_o;
        r_e   <= n_e;
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_ovalid;

    // Fill level never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("record count above capacity");

    // A merge cycle always has a record left in at least one run
    a_merge_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (i_act || j_act))
        else $error("merge step with both runs empty");

    // No input beat is taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !r_ovalid)
        else $error("input taken while output pending");

    // Delivering the final record clears the set
    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_stall && e_last) |=> (r_count == '0 && !r_ovf))
        else $error("set not cleared after final beat");

    // Emitted index stays inside the set
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_e < r_count))
        else $error("emit index outside set");

endmodule

// ===== src/bottom_up_merge_sorter.sv =====
// Top level of the bottom-up merge sorter: controller plus datapath.
// Depends on bms_pkg, bms_ctrl and bms_datapath.
//
//   channel  direction  handshake                  beat fields
//   input    in         i_in_valid / o_in_stall    i_key, i_payload, i_last
//   output   out        o_out_valid / i_out_stall  o_key_res, o_payload_res,
//                                                  o_last_res, o_dropped
//
// Loading accepts a beat whenever i_in_valid is high. After the beat marked
// last, ceil(log2 n) merge passes run (at least one); the shared compare
// unit writes one record per cycle while merging. Each emitted beat is read
// from the store, then loaded into the output register. Reset (i_rst_n low,
// synchronous) clears the control state; stores need no clearing. Input is
// stalled from the last beat until the final sorted beat is taken; output
// stalls hold the current beat.
module bottom_up_merge_sorter
    import bms_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_key,
    input  logic [31:0] i_payload,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_key_res,
    output logic [31:0] o_payload_res,
    output logic        o_last_res,
    output logic        o_dropped
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;

    bms_ctrl #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rd_addr0  (rd_addr0),
        .o_rd_addr1  (rd_addr1),
        .o_wr_addr   (wr_addr)
    );

    bms_datapath #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_rd_addr0    (rd_addr0),
        .i_rd_addr1    (rd_addr1),
        .i_wr_addr     (wr_addr),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_sts         (sts),
        .o_key_res     (o_key_res),
        .o_payload_res (o_payload_res),
        .o_last_res    (o_last_res),
        .o_dropped     (o_dropped)
    );

endmodule
